// ===== rtl/gf2d_pkg.sv =====
// Shared constants and types of the 2D gravitational force unit.
package gf2d_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int MASS_W      = 32;
    localparam int GRAV_W      = 32;
    localparam int DSQ_W       = 48;
    localparam int OUT_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 48;

    localparam int D_W         = COORD_WIDTH + 1;
    localparam int SQ_W        = 2 * D_W;
    localparam int SQ_STEPS    = D_W;
    localparam int SQ_REM_W    = D_W + 1;

    localparam int GM_W        = GRAV_W + MASS_W;
    localparam int HALF_W      = GM_W / 2;
    localparam int PP_W        = HALF_W + MASS_W;
    localparam int P_W         = GM_W + MASS_W;

    localparam int MAG_W       = 64;
    localparam int MAG_STEPS   = MAG_W;
    localparam int PT_W        = P_W - FRAC_BITS - MAG_W;
    localparam int DS_W        = SQ_W - FRAC_BITS;
    localparam int CMP_W       = (DS_W > DSQ_W) ? DS_W : DSQ_W;

    localparam int DIV_W       = (D_W > DSQ_W) ? D_W : DSQ_W;
    localparam int NUM_W       = MAG_W;
    localparam int MH_W        = MAG_W / 2;
    localparam int PM_W        = MH_W + D_W;
    localparam int N_W         = MAG_W + D_W;
    localparam int COMP_STEPS  = OUT_W;

    // sideband line positions
    localparam int LEN_DLY     = MAG_STEPS + 2 - (SQ_STEPS - 1);
    localparam int SB_SAT      = 1;
    localparam int SB_M2       = MAG_STEPS + 2;
    localparam int SB_OVF      = MAG_STEPS + 3;
    localparam int SB_DEPTH    = MAG_STEPS + 3 + COMP_STEPS;
    localparam int FRONT       = 4;
    localparam int VLD_DEPTH   = FRONT + SB_DEPTH + 1;

    localparam logic [GRAV_W-1:0] GRAV_RST = GRAV_W'(1) << FRAC_BITS;
    localparam logic [DSQ_W-1:0]  MIN_RST  = DSQ_W'(1) << FRAC_BITS;
    localparam logic [DSQ_W-1:0]  MAX_RST  = '1;

    localparam logic [OUT_W-1:0]  LIM_POS  = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0]  LIM_NEG  = {1'b1, {(OUT_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_GRAV    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DSQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DSQ = 2'd2;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
        logic [DIV_W-1:0] den;
    } div_word_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [SQ_W-1:0]     rad;
        logic [D_W-1:0]      root;
    } sqrt_word_t;

    typedef struct packed {
        logic           zero;
        logic           nx;
        logic           ny;
        logic [D_W-1:0] mx;
        logic [D_W-1:0] my;
        logic           sat_mag;
        logic           ovf_x;
        logic           ovf_y;
    } side_t;

endpackage

// ===== rtl/gravitational_force_2d_unit.sv =====
// Top level of the pipelined 2D gravitational force unit.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  command  | start / busy         | pos_a_x pos_a_y pos_b_x pos_b_y mass_a mass_b
//  result   | done (strobe)        | force_x force_y saturated
//  config   | cfg_valid/cfg_ready  | cfg_index cfg_data
//
// One transaction per cycle while busy is low; each result is strobed on done
// once its command has passed the VLD_DEPTH valid line. Depth is set by the
// 64-cell magnitude division row followed by the 32-cell component division
// rows. busy is high in reset and clears on the clock after it. Results are
// strobed on done for one cycle; the receiver cannot stall.
module gravitational_force_2d_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [gf2d_pkg::COORD_WIDTH-1:0] pos_a_x,
    input  logic signed [gf2d_pkg::COORD_WIDTH-1:0] pos_a_y,
    input  logic signed [gf2d_pkg::COORD_WIDTH-1:0] pos_b_x,
    input  logic signed [gf2d_pkg::COORD_WIDTH-1:0] pos_b_y,
    input  logic        [gf2d_pkg::MASS_W-1:0]      mass_a,
    input  logic        [gf2d_pkg::MASS_W-1:0]      mass_b,
    output logic                                    done,
    output logic signed [gf2d_pkg::OUT_W-1:0]       force_x,
    output logic signed [gf2d_pkg::OUT_W-1:0]       force_y,
    output logic                                    saturated,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic        [gf2d_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [gf2d_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gf2d_pkg::*;

    logic [GRAV_W-1:0]  grav_reg;
    logic [DSQ_W-1:0]   min_dsq_reg;
    logic [DSQ_W-1:0]   max_dsq_reg;
    logic               busy_reg;
    logic [VLD_DEPTH-1:0] vld_reg;

    // front stages
    logic [D_W-1:0]     s1_dx_reg, s1_dy_reg;
    logic [GM_W-1:0]    s1_gm_reg;
    logic [MASS_W-1:0]  s1_mb_reg;
    side_t              s2_side_reg, s3_side_reg, s4_side_reg;
    side_t              s2_side_next;
    logic [GM_W-1:0]    s2_gm_reg;
    logic [MASS_W-1:0]  s2_mb_reg;
    logic [SQ_W-1:0]    s3_sqx_reg, s3_sqy_reg;
    logic [PP_W-1:0]    s3_pl_reg, s3_ph_reg;
    logic [SQ_W-1:0]    s4_sq_reg;
    logic [P_W-1:0]     s4_p_reg;
    logic [DSQ_W-1:0]   s5_dsq_reg;
    logic [P_W-1:0]     s5_p_reg;

    logic [DS_W-1:0]    ds;
    logic [CMP_W-1:0]   ds_lo;
    logic [DSQ_W-1:0]   dsq_next;
    logic               sat_cmp;

    side_t              sb_reg  [SB_DEPTH];
    side_t              sb_next [SB_DEPTH];
    logic [D_W-1:0]     len_reg [LEN_DLY];

    sqrt_word_t         sq_w [SQ_STEPS+1];
    div_word_t          mag_w [MAG_STEPS+1];
    div_word_t          cx_w [COMP_STEPS+1];
    div_word_t          cy_w [COMP_STEPS+1];

    logic [MAG_W-1:0]   mag;
    logic [PM_W-1:0]    m1_xlo_reg, m1_xhi_reg, m1_ylo_reg, m1_yhi_reg;
    logic [N_W-1:0]     m2_nx_reg, m2_ny_reg;
    logic [D_W-1:0]     len;
    logic               ovf_x, ovf_y;

    logic [OUT_W-1:0]   qx, qy, lim_x, lim_y, vx, vy;
    logic               satx, saty;
    side_t              sb_last;
    logic [OUT_W-1:0]   force_x_reg, force_y_reg;
    logic               sat_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_reg    <= GRAV_RST;
            min_dsq_reg <= MIN_RST;
            max_dsq_reg <= MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GRAV:    grav_reg    <= cfg_data[GRAV_W-1:0];
                CFG_MIN_DSQ: min_dsq_reg <= cfg_data[DSQ_W-1:0];
                CFG_MAX_DSQ: max_dsq_reg <= cfg_data[DSQ_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            vld_reg  <= '0;
        end
        else
        begin
            busy_reg <= 1'b0;
            vld_reg  <= {vld_reg[VLD_DEPTH-2:0], start && !busy_reg};
        end
    end

    assign busy = busy_reg;

    // front: differences, magnitudes, products
    always_comb
    begin
        s2_side_next         = '0;
        s2_side_next.nx      = s1_dx_reg[D_W-1];
        s2_side_next.ny      = s1_dy_reg[D_W-1];
        s2_side_next.mx      = s1_dx_reg[D_W-1] ? D_W'(-s1_dx_reg) : s1_dx_reg;
        s2_side_next.my      = s1_dy_reg[D_W-1] ? D_W'(-s1_dy_reg) : s1_dy_reg;
        s2_side_next.zero    = (s1_dx_reg == '0) && (s1_dy_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        s1_dx_reg   <= {pos_b_x[COORD_WIDTH-1], pos_b_x} - {pos_a_x[COORD_WIDTH-1], pos_a_x};
        s1_dy_reg   <= {pos_b_y[COORD_WIDTH-1], pos_b_y} - {pos_a_y[COORD_WIDTH-1], pos_a_y};
        s1_gm_reg   <= GM_W'(grav_reg) * GM_W'(mass_a);
        s1_mb_reg   <= mass_b;

        s2_side_reg <= s2_side_next;
        s2_gm_reg   <= s1_gm_reg;
        s2_mb_reg   <= s1_mb_reg;

        s3_side_reg <= s2_side_reg;
        s3_sqx_reg  <= SQ_W'(s2_side_reg.mx) * SQ_W'(s2_side_reg.mx);
        s3_sqy_reg  <= SQ_W'(s2_side_reg.my) * SQ_W'(s2_side_reg.my);
        s3_pl_reg   <= PP_W'(s2_gm_reg[HALF_W-1:0]) * PP_W'(s2_mb_reg);
        s3_ph_reg   <= PP_W'(s2_gm_reg[GM_W-1:HALF_W]) * PP_W'(s2_mb_reg);

        s4_side_reg <= s3_side_reg;
        s4_sq_reg   <= s3_sqx_reg + s3_sqy_reg;
        s4_p_reg    <= {s3_ph_reg, HALF_W'(0)} + P_W'(s3_pl_reg);

        s5_dsq_reg  <= dsq_next;
        s5_p_reg    <= s4_p_reg;
    end

    // clamp of the squared distance, minimum first
    always_comb
    begin
        ds       = s4_sq_reg[SQ_W-1:FRAC_BITS];
        ds_lo    = (CMP_W'(ds) < CMP_W'(min_dsq_reg)) ? CMP_W'(min_dsq_reg) : CMP_W'(ds);
        dsq_next = (ds_lo > CMP_W'(max_dsq_reg)) ? max_dsq_reg : DSQ_W'(ds_lo);
    end

    // square root row
    assign sq_w[0] = '{rem: '0, rad: s4_sq_reg, root: '0};

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        gf2d_sqrt_cell u_cell (
            .clk      (clk),
            .in_word  (sq_w[k]),
            .out_word (sq_w[k+1])
        );
    end

    // magnitude division row
    assign sat_cmp  = DIV_W'(s5_p_reg[P_W-1 -: PT_W]) >= DIV_W'(s5_dsq_reg);
    assign mag_w[0] = '{rem: DIV_W'(s5_p_reg[P_W-1 -: PT_W]),
                        num: s5_p_reg[FRAC_BITS +: MAG_W],
                        quo: '0,
                        den: DIV_W'(s5_dsq_reg)};

    for (genvar j = 0; j < MAG_STEPS; j++)
    begin : g_mag
        gf2d_div_cell u_cell (
            .clk      (clk),
            .in_word  (mag_w[j]),
            .out_word (mag_w[j+1])
        );
    end

    assign mag = sb_reg[MAG_STEPS].sat_mag ? '1 : mag_w[MAG_STEPS].quo;

    // component products
    always_ff @(posedge clk)
    begin
        m1_xlo_reg <= PM_W'(mag[MH_W-1:0]) * PM_W'(sb_reg[MAG_STEPS].mx);
        m1_xhi_reg <= PM_W'(mag[MAG_W-1:MH_W]) * PM_W'(sb_reg[MAG_STEPS].mx);
        m1_ylo_reg <= PM_W'(mag[MH_W-1:0]) * PM_W'(sb_reg[MAG_STEPS].my);
        m1_yhi_reg <= PM_W'(mag[MAG_W-1:MH_W]) * PM_W'(sb_reg[MAG_STEPS].my);
        m2_nx_reg  <= {m1_xhi_reg, MH_W'(0)} + N_W'(m1_xlo_reg);
        m2_ny_reg  <= {m1_yhi_reg, MH_W'(0)} + N_W'(m1_ylo_reg);
    end

    // length delay line
    always_ff @(posedge clk)
    begin
        len_reg[0] <= sq_w[SQ_STEPS].root;
        for (int i = 1; i < LEN_DLY; i++)
        begin
            len_reg[i] <= len_reg[i-1];
        end
    end

    assign len   = len_reg[LEN_DLY-1];
    assign ovf_x = m2_nx_reg[N_W-1:OUT_W] >= (N_W-OUT_W)'(len);
    assign ovf_y = m2_ny_reg[N_W-1:OUT_W] >= (N_W-OUT_W)'(len);

    assign cx_w[0] = '{rem: DIV_W'(m2_nx_reg[OUT_W +: D_W]),
                       num: {m2_nx_reg[OUT_W-1:0], (NUM_W-OUT_W)'(0)},
                       quo: '0,
                       den: DIV_W'(len)};
    assign cy_w[0] = '{rem: DIV_W'(m2_ny_reg[OUT_W +: D_W]),
                       num: {m2_ny_reg[OUT_W-1:0], (NUM_W-OUT_W)'(0)},
                       quo: '0,
                       den: DIV_W'(len)};

    for (genvar c = 0; c < COMP_STEPS; c++)
    begin : g_comp
        gf2d_div_cell u_cell_x (
            .clk      (clk),
            .in_word  (cx_w[c]),
            .out_word (cx_w[c+1])
        );
        gf2d_div_cell u_cell_y (
            .clk      (clk),
            .in_word  (cy_w[c]),
            .out_word (cy_w[c+1])
        );
    end

    // sideband line
    always_comb
    begin
        sb_next[0] = s4_side_reg;
        for (int i = 1; i < SB_DEPTH; i++)
        begin
            sb_next[i] = sb_reg[i-1];
        end
        sb_next[SB_SAT].sat_mag = sat_cmp;
        sb_next[SB_OVF].ovf_x   = ovf_x;
        sb_next[SB_OVF].ovf_y   = ovf_y;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SB_DEPTH; i++)
        begin
            sb_reg[i] <= sb_next[i];
        end
    end

    // saturation and sign
    always_comb
    begin
        sb_last = sb_reg[SB_DEPTH-1];
        qx      = cx_w[COMP_STEPS].quo[OUT_W-1:0];
        qy      = cy_w[COMP_STEPS].quo[OUT_W-1:0];
        lim_x   = sb_last.nx ? LIM_NEG : LIM_POS;
        lim_y   = sb_last.ny ? LIM_NEG : LIM_POS;
        satx    = sb_last.ovf_x || (qx > lim_x);
        saty    = sb_last.ovf_y || (qy > lim_y);
        vx      = satx ? lim_x : qx;
        vy      = saty ? lim_y : qy;
    end

    always_ff @(posedge clk)
    begin
        if (sb_last.zero)
        begin
            force_x_reg <= '0;
            force_y_reg <= '0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            force_x_reg <= sb_last.nx ? OUT_W'(-vx) : vx;
            force_y_reg <= sb_last.ny ? OUT_W'(-vy) : vy;
            sat_reg     <= sb_last.sat_mag || satx || saty;
        end
    end

    assign done      = vld_reg[VLD_DEPTH-1];
    assign force_x   = force_x_reg;
    assign force_y   = force_y_reg;
    assign saturated = sat_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##VLD_DEPTH done)
        else $error("command transaction did not produce a result on time");

    a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[VLD_DEPTH-2] && sb_reg[SB_DEPTH-1].zero
        |=> force_x == '0 && force_y == '0 && !saturated)
        else $error("coincident bodies gave a nonzero force");

    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n |=> !busy)
        else $error("busy raised outside reset");

    a_grav_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && cfg_index == CFG_GRAV
        |=> grav_reg == $past(cfg_data[GRAV_W-1:0]))
        else $error("grav_constant write lost");
`endif

endmodule

// ===== rtl/gf2d_sqrt_cell.sv =====
// One registered step of the integer square root row.
module gf2d_sqrt_cell (
    input  logic                   clk,
    input  gf2d_pkg::sqrt_word_t   in_word,
    output gf2d_pkg::sqrt_word_t   out_word
);
    import gf2d_pkg::*;

    logic [SQ_REM_W+1:0] trial_sum;
    logic [SQ_REM_W+1:0] trial;
    logic                take;
    sqrt_word_t          word_next;
    sqrt_word_t          word_reg;

    always_comb
    begin
        trial_sum      = {in_word.rem, in_word.rad[SQ_W-1 -: 2]};
        trial          = (SQ_REM_W+2)'({in_word.root, 2'b01});
        take           = (trial_sum >= trial);
        word_next.rem  = take ? SQ_REM_W'(trial_sum - trial) : SQ_REM_W'(trial_sum);
        word_next.rad  = {in_word.rad[SQ_W-3:0], 2'b00};
        word_next.root = {in_word.root[D_W-2:0], take};
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_word = word_reg;

endmodule

// ===== rtl/gf2d_div_cell.sv =====
// One registered step of a restoring division row.
module gf2d_div_cell (
    input  logic                  clk,
    input  gf2d_pkg::div_word_t   in_word,
    output gf2d_pkg::div_word_t   out_word
);
    import gf2d_pkg::*;

    logic [DIV_W:0] trial_sum;
    logic [DIV_W:0] den_ext;
    logic           take;
    div_word_t      word_next;
    div_word_t      word_reg;

    always_comb
    begin
        trial_sum     = {in_word.rem, in_word.num[NUM_W-1]};
        den_ext       = {1'b0, in_word.den};
        take          = (trial_sum >= den_ext);
        word_next.rem = take ? DIV_W'(trial_sum - den_ext) : DIV_W'(trial_sum);
        word_next.num = {in_word.num[NUM_W-2:0], 1'b0};
        word_next.quo = {in_word.quo[NUM_W-2:0], take};
        word_next.den = in_word.den;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_word = word_reg;

endmodule
